/* rtl/core/accsd_pkg.sv */
// ----------------------------------------------------------------------------
// accsd_pkg
// Shared constants and controller/datapath interface types of the shake
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package accsd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // input word kinds (tuser)
  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 2'd3;

  // register reset values
  localparam logic [15:0] SENSITIVITY_RST = 16'd435;
  localparam logic [8:0]  FILTER_COEF_RST = 9'd205;
  localparam logic [15:0] LOCKOUT_RST     = 16'd1500;
  localparam logic [15:0] HOLDOFF_RST     = 16'd3000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;     // latch input word, clear root state
    logic       sq_en;    // square one axis and accumulate
    logic [1:0] sq_idx;   // axis being squared
    logic       root_en;  // one square root digit
    logic       f1_en;    // first filter product, delta
    logic       f2_en;    // second filter product
    logic       fin_en;   // update state, write output register
  } cmd_t;

  typedef struct packed {
    logic sample_in;  // word on the input is a sample
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/accel_shake_detector.sv */
// A sample passes through squaring of the three axes, SAMPLE_BITS square root digits,
//   two filter steps and the update, which writes the output register.
// Tick, restart and unused words go from acceptance straight to the update.
// One word in flight: a new word is accepted only once the last has reached the output register.
//   Next word accepted while a result waits; a full output register stalls the update.
// Reset: async active low, restores registers, clears filter, loads lockout with 4500.
// ----------------------------------------------------------------------------
// accel_shake_detector
// Shake detection on accelerometer samples: magnitude, smoothed change,
// threshold with lockout.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_shake_detector #(
  parameter int unsigned SAMPLE_BITS = accsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [47:0]                      s_axis_tdata,  // accel_x, accel_y, accel_z
  input  wire  [1:0]                       s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // filtered_change, zero pad
  output logic                             m_axis_tuser,  // shake
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [accsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [15:0]                      cfg_data_i
);

  accsd_pkg::cmd_t    cmd;
  accsd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  accsd_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  accsd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

/* rtl/core/accsd_ctrl.sv */
// ----------------------------------------------------------------------------
// accsd_ctrl
// Sequencer: squares, square root digits, filter steps, result write.
// ----------------------------------------------------------------------------
`default_nettype none

module accsd_ctrl #(
  parameter int unsigned SAMPLE_BITS = accsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  accsd_pkg::status_t   status_i,
  output accsd_pkg::cmd_t      cmd_o
);

  localparam int unsigned CW = $clog2(SAMPLE_BITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_F1   = 3'd3;
  localparam logic [2:0] ST_F2   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sq_idx = cnt_q[1:0];
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = status_i.sample_in ? ST_SQ : ST_FIN;
        end
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        if (cnt_q == CW'(2)) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_ROOT: begin
        cmd_o.root_en = 1'b1;
        if (cnt_q == CW'(SAMPLE_BITS - 1)) begin
          state_d = ST_F1;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_F1: begin
        cmd_o.f1_en = 1'b1;
        state_d     = ST_F2;
      end
      ST_F2: begin
        cmd_o.f2_en = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        // wait until the output register frees up
        if (status_i.out_free) begin
          cmd_o.fin_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/accsd_datapath.sv */
// ----------------------------------------------------------------------------
// accsd_datapath
// Config registers, squares, digit-serial square root, high-pass filter,
// lockout counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module accsd_datapath #(
  parameter int unsigned SAMPLE_BITS = accsd_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  accsd_pkg::cmd_t                   cmd_i,
  output accsd_pkg::status_t                status_o,
  input  wire  [47:0]                       s_axis_tdata,
  input  wire  [1:0]                        s_axis_tuser,
  input  wire                               cfg_valid_i,
  input  wire  [accsd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [15:0]                       cfg_data_i,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [23:0]                       m_axis_tdata,
  output logic                              m_axis_tuser
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SQW = 2 * SB;
  localparam int unsigned RW  = SB + 3;

  // configuration
  logic [15:0] sens_q, lock_ms_q, hold_ms_q;
  logic [8:0]  coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q    <= accsd_pkg::SENSITIVITY_RST;
      coef_q    <= accsd_pkg::FILTER_COEF_RST;
      lock_ms_q <= accsd_pkg::LOCKOUT_RST;
      hold_ms_q <= accsd_pkg::HOLDOFF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        accsd_pkg::REG_SENSITIVITY: sens_q    <= cfg_data_i;
        accsd_pkg::REG_FILTER_COEF: coef_q    <= cfg_data_i[8:0];
        accsd_pkg::REG_LOCKOUT:     lock_ms_q <= cfg_data_i;
        accsd_pkg::REG_HOLDOFF:     hold_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word
  logic [1:0]  mode_q;
  logic [15:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= s_axis_tuser;
      x_q    <= s_axis_tdata[15:0];
      y_q    <= s_axis_tdata[31:16];
      z_q    <= s_axis_tdata[47:32];
    end
  end

  assign status_o.sample_in = (s_axis_tuser == accsd_pkg::MODE_SAMPLE);

  // axis values: low SB bits, read as signed; wider axes see a zero-extended field
  logic signed [SB-1:0] ax_x, ax_y, ax_z, ax_sel;

  if (SB <= 16) begin : g_narrow
    assign ax_x = x_q[SB-1:0];
    assign ax_y = y_q[SB-1:0];
    assign ax_z = z_q[SB-1:0];
  end else begin : g_wide
    assign ax_x = {{(SB-16){1'b0}}, x_q};
    assign ax_y = {{(SB-16){1'b0}}, y_q};
    assign ax_z = {{(SB-16){1'b0}}, z_q};
  end

  always_comb begin
    case (cmd_i.sq_idx)
      2'd0:    ax_sel = ax_x;
      2'd1:    ax_sel = ax_y;
      default: ax_sel = ax_z;
    endcase
  end

  logic signed [SQW-1:0] sq_prod;
  assign sq_prod = ax_sel * ax_sel;

  // sum of squares, then shifted out two bits per root digit
  logic [SQW-1:0] acc_sq_q;
  logic [RW-1:0]  rem_q;
  logic [SB-1:0]  root_q;

  logic [RW-1:0] rem_sh, trial;
  logic          digit;

  assign rem_sh = {rem_q[RW-3:0], acc_sq_q[SQW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign digit  = (rem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_en) begin
      if (cmd_i.sq_idx == 2'd0) begin
        acc_sq_q <= sq_prod;
      end else begin
        acc_sq_q <= acc_sq_q + sq_prod;
      end
    end else if (cmd_i.root_en) begin
      acc_sq_q <= acc_sq_q << 2;
      rem_q    <= digit ? (rem_sh - trial) : rem_sh;
      root_q   <= {root_q[SB-2:0], digit};
    end
  end

  logic [15:0] mag;

  if (SB > 16) begin : g_sat
    assign mag = (|root_q[SB-1:16]) ? 16'hFFFF : root_q[15:0];
  end else begin : g_nosat
    assign mag = 16'(root_q);
  end

  // detector state
  logic [15:0]        prev_q;
  logic signed [16:0] smooth_q, smooth_d;
  logic [16:0]        lockcnt_q;
  logic signed [16:0] delta_q;
  logic signed [27:0] acc_f_q;

  logic [8:0]         a_eff;
  logic signed [26:0] p1, p2;

  assign a_eff = (coef_q > 9'd256) ? 9'd256 : coef_q;
  assign p1    = smooth_q * $signed({1'b0, a_eff});
  assign p2    = delta_q * $signed(10'd256 - {1'b0, a_eff});

  always_ff @(posedge clk_i) begin
    if (cmd_i.f1_en) begin
      acc_f_q <= 28'(p1);
      delta_q <= $signed({1'b0, mag}) - $signed({1'b0, prev_q});
    end else if (cmd_i.f2_en) begin
      acc_f_q <= acc_f_q + 28'(p2);
    end
  end

  // round half up, saturate to 17 bits signed
  logic signed [27:0] biased;
  logic signed [19:0] rnd;
  logic signed [16:0] fsat;
  logic               over_thr, shake_hit;

  assign biased = acc_f_q + 28'sd128;
  assign rnd    = biased[27:8];

  always_comb begin
    if (rnd > 20'sd65535) begin
      fsat = 17'sd65535;
    end else if (rnd < -20'sd65536) begin
      fsat = -17'sd65536;
    end else begin
      fsat = rnd[16:0];
    end
  end

  assign over_thr  = $signed({fsat[16], fsat}) > $signed({2'b00, sens_q});
  assign shake_hit = over_thr && (lockcnt_q == 17'd0) && (mode_q == accsd_pkg::MODE_SAMPLE);

  logic [15:0] prev_d;
  logic [16:0] lockcnt_d;

  always_comb begin
    prev_d    = prev_q;
    smooth_d  = smooth_q;
    lockcnt_d = lockcnt_q;
    case (mode_q)
      accsd_pkg::MODE_SAMPLE: begin
        prev_d   = mag;
        smooth_d = fsat;
        if (shake_hit) begin
          lockcnt_d = {1'b0, lock_ms_q};
        end
      end
      accsd_pkg::MODE_TICK: begin
        if (lockcnt_q != 17'd0) begin
          lockcnt_d = lockcnt_q - 17'd1;
        end
      end
      accsd_pkg::MODE_RESTART: begin
        prev_d    = '0;
        smooth_d  = '0;
        lockcnt_d = {1'b0, hold_ms_q} + {1'b0, lock_ms_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      smooth_q  <= '0;
      lockcnt_q <= {1'b0, accsd_pkg::HOLDOFF_RST} + {1'b0, accsd_pkg::LOCKOUT_RST};
    end else if (cmd_i.fin_en) begin
      prev_q    <= prev_d;
      smooth_q  <= smooth_d;
      lockcnt_q <= lockcnt_d;
    end
  end

  // output register
  logic        out_vld_q;
  logic        out_shake_q;
  logic [16:0] out_filt_q;

  assign status_o.out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      out_shake_q <= shake_hit;
      out_filt_q  <= smooth_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_filt_q};
  assign m_axis_tuser  = out_shake_q;

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for accel_shake_detector. Sample, tick, restart and
// unused words go through the input stream while the output stream stalls
// at random. Each reading out is checked against a typed row's value or an
// in-bench model of magnitude, smoothing filter and lockout. Register settings
// change between phases. A short directed table runs first, then random phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CFG_IDX_W = accsd_pkg::CFG_IDX_W;
  localparam logic [1:0] MODE_SAMPLE  = accsd_pkg::MODE_SAMPLE;
  localparam logic [1:0] MODE_TICK    = accsd_pkg::MODE_TICK;
  localparam logic [1:0] MODE_RESTART = accsd_pkg::MODE_RESTART;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = accsd_pkg::REG_SENSITIVITY;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = accsd_pkg::REG_FILTER_COEF;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT     = accsd_pkg::REG_LOCKOUT;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = accsd_pkg::REG_HOLDOFF;
  localparam logic [15:0] SENSITIVITY_RST = accsd_pkg::SENSITIVITY_RST;
  localparam logic [8:0]  FILTER_COEF_RST = accsd_pkg::FILTER_COEF_RST;
  localparam logic [15:0] LOCKOUT_RST     = accsd_pkg::LOCKOUT_RST;
  localparam logic [15:0] HOLDOFF_RST     = accsd_pkg::HOLDOFF_RST;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned DRAIN_CYCLES = 30;

  typedef struct packed {
    logic        shake;
    logic [16:0] change;
  } reading_t;

  // a..d: x, y, z for a word row; sensitivity, coeff, lockout, holdoff for a regs row
  typedef struct packed {
    logic        regs;
    logic [1:0]  mode;
    logic [15:0] a, b, c, d;
    logic        typed;
    reading_t    want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata;   // accel_x, accel_y, accel_z
  logic [1:0]           s_axis_tuser;   // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;   // filtered_change, zero pad
  logic                 m_axis_tuser;   // shake
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;

  // model copy of the registers and detector state
  logic [15:0]        sens_r, lock_ms_r, hold_r;
  logic [8:0]         coef_r;
  logic [15:0]        prev_mag_r;
  logic signed [16:0] smooth_r;
  logic [16:0]        lockout_r;

  reading_t  expected_readings[$];
  stim_row_t directed[$];
  int        mismatches = 0;

  accel_shake_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic void restart_model();
    prev_mag_r = '0;
    smooth_r   = '0;
    lockout_r  = {1'b0, hold_r} + {1'b0, lock_ms_r};
  endfunction

  function automatic reading_t predict_reading(input logic [1:0] mode,
                                               input logic signed [15:0] x, y, z);
    reading_t r;
    longint   sq, mag, trial, dlt, a, f;
    int       b;
    r.shake = 1'b0;
    case (mode)
      MODE_SAMPLE: begin
        sq  = longint'(x) * x + longint'(y) * y + longint'(z) * z;
        mag = 0;
        for (b = 16; b >= 0; b--) begin
          trial = mag + (longint'(1) << b);
          if (trial * trial <= sq) mag = trial;
        end
        if (mag > 65535) mag = 65535;
        dlt        = mag - longint'(prev_mag_r);
        prev_mag_r = mag[15:0];
        a = (coef_r > 9'd256) ? 256 : longint'(coef_r);
        // round half up, floor shift on the signed sum
        f = (longint'(smooth_r) * a + dlt * (256 - a) + 128) >>> 8;
        if (f > 65535) f = 65535;
        if (f < -65536) f = -65536;
        smooth_r = f[16:0];
        if (f > longint'(sens_r) && lockout_r == '0) begin
          r.shake   = 1'b1;
          lockout_r = {1'b0, lock_ms_r};
        end
      end
      MODE_TICK: begin
        if (lockout_r != '0) lockout_r = lockout_r - 17'd1;
      end
      MODE_RESTART: begin
        restart_model();
      end
      default: ;
    endcase
    r.change = smooth_r;
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic [1:0] mode,
                                         input logic [15:0] x, y, z);
    stim_row_t row;
    row      = '0;
    row.mode = mode;
    row.a    = x;
    row.b    = y;
    row.c    = z;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [1:0] mode, input logic [15:0] x, y, z,
                                          input logic shake, input logic [16:0] change);
    stim_row_t row;
    row             = word_row(mode, x, y, z);
    row.typed       = 1'b1;
    row.want.shake  = shake;
    row.want.change = change;
    return row;
  endfunction

  function automatic stim_row_t regs_row(input logic [15:0] sens, coef, lock, hold);
    stim_row_t row;
    row      = '0;
    row.regs = 1'b1;
    row.a    = sens;
    row.b    = coef;
    row.c    = lock;
    row.d    = hold;
    return row;
  endfunction

  function automatic logic [15:0] pick_corner();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // tvalid stays high when the next word follows right away
  task automatic send_word(input logic [1:0] mode, input logic [15:0] x, y, z,
                           input logic typed, input reading_t want);
    reading_t pred;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_reading(mode, x, y, z);
    expected_readings.push_back(typed ? want : pred);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SENSITIVITY: sens_r    = data;
      REG_FILTER_COEF: coef_r    = data[8:0];
      REG_LOCKOUT:     lock_ms_r = data;
      REG_HOLDOFF:     hold_r    = data;
      default: ;
    endcase
  endtask

  // only with the block idle: every reading back, then a short pause
  task automatic write_regs(input logic [15:0] sens, coef, lock, hold);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_write(REG_SENSITIVITY, sens);
    cfg_write(REG_FILTER_COEF, coef);
    cfg_write(REG_LOCKOUT, lock);
    cfg_write(REG_HOLDOFF, hold);
    cfg_valid_i <= 1'b0;
  endtask

  // output side: long ready runs, short stalls, sometimes none
  initial begin
    int n_on, n_off;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n_on  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
      n_off = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (n_on) @(posedge clk_i);
      if (n_off > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n_off) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected word shake=%0b change=%0d",
                   m_axis_tuser, $signed(m_axis_tdata[16:0]));
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tuser !== want.shake || m_axis_tdata[16:0] !== want.change) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch at %0t: shake exp %0b got %0b, change exp %0d got %0d",
                     $realtime, want.shake, m_axis_tuser,
                     $signed(want.change), $signed(m_axis_tdata[16:0]));
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [1:0]  mode;
    logic [15:0] x, y, z, sens, coef, lock, hold;
    int          pick, burst_left;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_SAMPLE;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_SENSITIVITY;
    cfg_data_i    <= '0;
    sens_r    = SENSITIVITY_RST;
    coef_r    = FILTER_COEF_RST;
    lock_ms_r = LOCKOUT_RST;
    hold_r    = HOLDOFF_RST;
    restart_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, mode 3 and restart with reset registers
    directed.push_back(typed_row(MODE_TICK, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(typed_row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 17'd0));
    directed.push_back(typed_row(MODE_RESTART, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(typed_row(MODE_SAMPLE, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(word_row(MODE_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000));
    directed.push_back(word_row(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000));
    directed.push_back(word_row(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'h0001));
    directed.push_back(word_row(MODE_SAMPLE, 16'h0000, 16'hFFFF, 16'h7FFF));
    directed.push_back(word_row(MODE_TICK, 16'h0, 16'h0, 16'h0));
    // all registers zero: no smoothing, any rise is a shake
    directed.push_back(regs_row(16'd0, 16'd0, 16'd0, 16'd0));
    directed.push_back(typed_row(MODE_RESTART, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(typed_row(MODE_SAMPLE, 16'd256, 16'h0, 16'h0, 1'b1, 17'd256));
    directed.push_back(typed_row(MODE_SAMPLE, 16'd256, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(typed_row(MODE_SAMPLE, 16'h0, 16'h0, 16'h0, 1'b0, -17'sd256));
    // coefficient 256 and above: filter holds
    directed.push_back(regs_row(16'd0, 16'd256, 16'd0, 16'd0));
    directed.push_back(typed_row(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 1'b0, -17'sd256));
    directed.push_back(regs_row(16'd0, 16'hFFFF, 16'd0, 16'd0));
    directed.push_back(typed_row(MODE_SAMPLE, 16'd100, 16'd100, 16'd100, 1'b0, -17'sd256));
    // sensitivity, lockout and holdoff at max: longest lockout
    directed.push_back(regs_row(16'hFFFF, 16'd128, 16'hFFFF, 16'hFFFF));
    directed.push_back(typed_row(MODE_RESTART, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(word_row(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    directed.push_back(word_row(MODE_TICK, 16'h0, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_SAMPLE, 16'h0, 16'h0, 16'h0));
    // sample under lockout, count down to zero, tick at zero, then a shake
    directed.push_back(regs_row(16'd100, 16'd0, 16'd1, 16'd1));
    directed.push_back(typed_row(MODE_RESTART, 16'h0, 16'h0, 16'h0, 1'b0, 17'd0));
    directed.push_back(word_row(MODE_SAMPLE, 16'd1000, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_TICK, 16'h0, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_TICK, 16'h0, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_TICK, 16'h0, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_SAMPLE, 16'd3000, 16'h0, 16'h0));
    directed.push_back(word_row(MODE_SAMPLE, 16'd3000, 16'h0, 16'h0));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.regs) begin
        write_regs(row.a, row.b, row.c, row.d);
      end else begin
        send_word(row.mode, row.a, row.b, row.c, row.typed, row.want);
        pause(($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
      end
    end

    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      sens = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 3000));
      pick = $urandom_range(0, 9);
      coef = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd256 :
             (pick == 2) ? 16'($urandom_range(257, 65535)) : 16'($urandom_range(0, 256));
      pick = $urandom_range(0, 9);
      lock = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 40));
      pick = $urandom_range(0, 9);
      hold = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
      write_regs(sens, coef, lock, hold);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        mode = (pick < 50) ? MODE_SAMPLE : (pick < 90) ? MODE_TICK :
               (pick < 95) ? MODE_RESTART : MODE_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // device at rest: gravity on z plus a little noise
          x = 16'($urandom_range(0, 255)) - 16'd128;
          y = 16'($urandom_range(0, 255)) - 16'd128;
          z = 16'd256 + 16'($urandom_range(0, 255)) - 16'd128;
        end else if (pick < 8) begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end else begin
          x = pick_corner();
          y = pick_corner();
          z = pick_corner();
        end
        send_word(mode, x, y, z, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
